/* hdl/sha512_pkg.sv */
`timescale 1ns / 1ps
package sha512_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_PAD,
      ST_ROUND,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   localparam logic [1:0] VAR_512     = 2'd0;
   localparam logic [1:0] VAR_384     = 2'd1;
   localparam logic [1:0] VAR_512_224 = 2'd2;
   localparam logic [1:0] VAR_512_256 = 2'd3;

   localparam logic [6:0] PAD_LENGTH_POS = 7'd112;

   function automatic logic [63:0] round_constant(input logic [6:0] idx);
      logic [63:0] k;
      case (idx)
         7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
         7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
         7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
         7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
         7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
         default: k = 64'h0;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] initial_value(input logic [1:0] vsel,
                                                 input logic [2:0] idx);
      logic [63:0] v;
      case ({vsel, idx})
         5'd0: v = 64'h6a09e667f3bcc908;  5'd1: v = 64'hbb67ae8584caa73b;
         5'd2: v = 64'h3c6ef372fe94f82b;  5'd3: v = 64'ha54ff53a5f1d36f1;
         5'd4: v = 64'h510e527fade682d1;  5'd5: v = 64'h9b05688c2b3e6c1f;
         5'd6: v = 64'h1f83d9abfb41bd6b;  5'd7: v = 64'h5be0cd19137e2179;
         5'd8: v = 64'hcbbb9d5dc1059ed8;  5'd9: v = 64'h629a292a367cd507;
         5'd10: v = 64'h9159015a3070dd17; 5'd11: v = 64'h152fecd8f70e5939;
         5'd12: v = 64'h67332667ffc00b31; 5'd13: v = 64'h8eb44a8768581511;
         5'd14: v = 64'hdb0c2e0d64f98fa7; 5'd15: v = 64'h47b5481dbefa4fa4;
         5'd16: v = 64'h8c3d37c819544da2; 5'd17: v = 64'h73e1996689dcd4d6;
         5'd18: v = 64'h1dfab7ae32ff9c82; 5'd19: v = 64'h679dd514582f9fcf;
         5'd20: v = 64'h0f6d2b697bd44da8; 5'd21: v = 64'h77e36f7304c48942;
         5'd22: v = 64'h3f9d85a86a1d36c8; 5'd23: v = 64'h1112e6ad91d692a1;
         5'd24: v = 64'h22312194fc2bf72c; 5'd25: v = 64'h9f555fa3c84c64c2;
         5'd26: v = 64'h2393b86b6f53b151; 5'd27: v = 64'h963877195940eabd;
         5'd28: v = 64'h96283ee2a88effe3; 5'd29: v = 64'hbe5e1e2553863992;
         5'd30: v = 64'h2b0199fc2c85b8aa; 5'd31: v = 64'h0eb72ddc81c52ca2;
         default: v = 64'h0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/sha512_family_hash.sv */
`timescale 1ns / 1ps
// SHA-512 family hash core. Each request carries up to 8 message bytes; the
// bytes are written one per cycle into a 16-entry word buffer (held while a
// full block is compressed), and a new request is accepted only after all
// bytes of the previous one are written. When the 128-byte block fills, the
// single round unit runs 80 rounds, one per cycle, then adds the working
// values into the chain value. End of message pads one byte per cycle and
// compresses one or two more blocks, then streams 4, 6 or 8 digest words on
// the rsp channel. Writing the variant register aborts any message and
// reloads the initial value; write it only while idle.
module sha512_family_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_final_word,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   sha512_pkg::state_type state_ff, state_in;

   logic [1:0]  variant_ff;
   logic [63:0] chain_ff [8];
   logic [63:0] work_ff  [8];
   logic [63:0] sched_ff [16];
   logic [6:0]  fill_ff;
   logic [127:0] bits_ff;
   logic [127:0] len_ff;
   logic [63:0] data_ff;
   logic [3:0]  left_ff;
   logic        eom_ff;
   logic        padding_ff;
   logic        pad_first_ff;
   logic        late_ff;
   logic        len_sent_ff;
   logic [6:0]  round_ff;
   logic [2:0]  out_idx_ff;
   logic [2:0]  last_idx;

   logic        accept;
   logic [7:0]  byte_in;
   logic        byte_we;
   logic        len_byte;
   logic [63:0] t1, t2, w_cur, w_new, s0, s1, e_, a_;
   logic [63:0] w_mask, w_put;

   assign accept = req_valid && req_ready;

   // digest length per variant
   always_comb begin
      case (variant_ff)
         sha512_pkg::VAR_512: last_idx = 3'd7;
         sha512_pkg::VAR_384: last_idx = 3'd5;
         default:             last_idx = 3'd3;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha512_pkg::ST_IDLE: if (accept) state_in = sha512_pkg::ST_ABSORB;
         sha512_pkg::ST_ABSORB: begin
            if (fill_ff == 7'd127 && left_ff != 4'd0) state_in = sha512_pkg::ST_ROUND;
            else if (left_ff == 4'd0)
               state_in = eom_ff ? sha512_pkg::ST_PAD : sha512_pkg::ST_IDLE;
         end
         sha512_pkg::ST_PAD: if (fill_ff == 7'd127) state_in = sha512_pkg::ST_ROUND;
         sha512_pkg::ST_ROUND: if (round_ff == 7'd79) state_in = sha512_pkg::ST_FINISH;
         sha512_pkg::ST_FINISH: begin
            if (!padding_ff) state_in = sha512_pkg::ST_ABSORB;
            else if (len_sent_ff) state_in = sha512_pkg::ST_OUTPUT;
            else state_in = sha512_pkg::ST_PAD;
         end
         sha512_pkg::ST_OUTPUT:
            if (rsp_ready && out_idx_ff == last_idx) state_in = sha512_pkg::ST_IDLE;
         default: state_in = sha512_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == sha512_pkg::ST_IDLE);
      rsp_valid = (state_ff == sha512_pkg::ST_OUTPUT);
      rsp_final_word = (out_idx_ff == last_idx);
      rsp_digest_word = chain_ff[out_idx_ff];
      rsp_valid_bytes = 4'd8;
      if (variant_ff == sha512_pkg::VAR_512_224 && rsp_final_word) begin
         rsp_digest_word = {chain_ff[out_idx_ff][63:32], 32'h0};
         rsp_valid_bytes = 4'd4;
      end
   end

   // byte source for buffer write: message, pad marker, zeros, length
   // length goes in only when the pad marker landed before its field
   always_comb begin
      byte_we = 1'b0;
      byte_in = data_ff[63:56];
      len_byte = !pad_first_ff && !late_ff && (fill_ff >= sha512_pkg::PAD_LENGTH_POS);
      if (state_ff == sha512_pkg::ST_ABSORB && left_ff != 4'd0) byte_we = 1'b1;
      if (state_ff == sha512_pkg::ST_PAD) begin
         byte_we = 1'b1;
         if (pad_first_ff) byte_in = 8'h80;
         else if (len_byte) byte_in = len_ff[127:120];
         else byte_in = 8'h00;
      end
      w_mask = 64'hff << (6'd56 - {fill_ff[2:0], 3'b000});
      w_put  = {56'h0, byte_in} << (6'd56 - {fill_ff[2:0], 3'b000});
   end

   // shared round unit with rolling message schedule
   always_comb begin
      w_cur = sched_ff[0];
      s0 = {sched_ff[1][0], sched_ff[1][63:1]} ^ {sched_ff[1][7:0], sched_ff[1][63:8]}
           ^ (sched_ff[1] >> 7);
      s1 = {sched_ff[14][18:0], sched_ff[14][63:19]}
           ^ {sched_ff[14][60:0], sched_ff[14][63:61]} ^ (sched_ff[14] >> 6);
      w_new = s1 + sched_ff[9] + s0 + sched_ff[0];
      e_ = work_ff[4];
      a_ = work_ff[0];
      t1 = work_ff[7] + ({e_[13:0], e_[63:14]} ^ {e_[17:0], e_[63:18]} ^ {e_[40:0], e_[63:41]})
           + ((e_ & work_ff[5]) ^ (~e_ & work_ff[6]))
           + sha512_pkg::round_constant(round_ff) + w_cur;
      t2 = ({a_[27:0], a_[63:28]} ^ {a_[33:0], a_[63:34]} ^ {a_[38:0], a_[63:39]})
           + ((a_ & work_ff[1]) ^ (a_ & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha512_pkg::ST_IDLE;
         variant_ff <= sha512_pkg::VAR_512;
         fill_ff <= 7'd0;
         bits_ff <= 128'd0;
         out_idx_ff <= 3'd0;
         round_ff <= 7'd0;
         left_ff <= 4'd0;
         eom_ff <= 1'b0;
         padding_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         late_ff <= 1'b0;
         len_sent_ff <= 1'b0;
         for (int i = 0; i < 8; i++)
            chain_ff[i] <= sha512_pkg::initial_value(sha512_pkg::VAR_512, 3'(i));
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            variant_ff <= csr_write_data;
            fill_ff <= 7'd0;
            bits_ff <= 128'd0;
            for (int i = 0; i < 8; i++)
               chain_ff[i] <= sha512_pkg::initial_value(csr_write_data, 3'(i));
         end
         if (accept) begin
            data_ff <= req_data_word;
            left_ff <= (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
            eom_ff <= req_end_of_message;
            bits_ff <= bits_ff + {121'd0, ((req_byte_count > 4'd8) ? 4'd8 : req_byte_count),
                                  3'b000};
         end
         // buffer byte write into the schedule words
         if (byte_we && state_ff != sha512_pkg::ST_ROUND) begin
            sched_ff[fill_ff[6:3]] <= (sched_ff[fill_ff[6:3]] & ~w_mask) | w_put;
            fill_ff <= fill_ff + 7'd1;
            if (state_ff == sha512_pkg::ST_ABSORB) begin
               data_ff <= {data_ff[55:0], 8'h00};
               left_ff <= left_ff - 4'd1;
            end else begin
               pad_first_ff <= 1'b0;
               if (len_byte) begin
                  len_ff <= {len_ff[119:0], 8'h00};
                  if (fill_ff == 7'd127) len_sent_ff <= 1'b1;
               end
               // marker at or past the start of the length field pushes the length to the next block
               if (fill_ff == 7'd127) late_ff <= 1'b0;
               else if (pad_first_ff && fill_ff >= sha512_pkg::PAD_LENGTH_POS)
                  late_ff <= 1'b1;
            end
            if (fill_ff == 7'd127) begin
               round_ff <= 7'd0;
               for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
            end
         end
         if (state_ff == sha512_pkg::ST_ABSORB && left_ff == 4'd0 && eom_ff) begin
            padding_ff <= 1'b1;
            pad_first_ff <= 1'b1;
            late_ff <= 1'b0;
            len_sent_ff <= 1'b0;
            len_ff <= bits_ff;
            eom_ff <= 1'b0;
         end
         if (state_ff == sha512_pkg::ST_ROUND) begin
            round_ff <= round_ff + 7'd1;
            for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i + 1];
            sched_ff[15] <= w_new;
            work_ff[0] <= t1 + t2;
            work_ff[1] <= work_ff[0];
            work_ff[2] <= work_ff[1];
            work_ff[3] <= work_ff[2];
            work_ff[4] <= work_ff[3] + t1;
            work_ff[5] <= work_ff[4];
            work_ff[6] <= work_ff[5];
            work_ff[7] <= work_ff[6];
         end
         if (state_ff == sha512_pkg::ST_FINISH) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
         if (state_ff == sha512_pkg::ST_FINISH && state_in == sha512_pkg::ST_OUTPUT) begin
            out_idx_ff <= 3'd0;
            padding_ff <= 1'b0;
            len_sent_ff <= 1'b0;
         end
         // digest out, then restart with this variant
         if (state_ff == sha512_pkg::ST_OUTPUT && rsp_ready) begin
            out_idx_ff <= out_idx_ff + 3'd1;
            if (out_idx_ff == last_idx) begin
               fill_ff <= 7'd0;
               bits_ff <= 128'd0;
               for (int i = 0; i < 8; i++)
                  chain_ff[i] <= sha512_pkg::initial_value(variant_ff, 3'(i));
            end
         end
      end
   end

   // round counter stays within the 80 rounds
   property p_round_bounded;
      @(posedge clock) disable iff (reset)
         state_ff == sha512_pkg::ST_ROUND |-> round_ff <= 7'd79;
   endproperty
   assert property (p_round_bounded) else $error("round counter overran");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while digest pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_word) |=> state_ff == sha512_pkg::ST_IDLE)
      else $error("no return to idle after final digest word");

endmodule

/* test/sha512_family_hash_test.sv */
`timescale 1ns / 1ps
module sha512_family_hash_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 250;

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] START_IV [32] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179,
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4,
      64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
      64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1,
      64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
      64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2
   };

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } digest_word_type;

   typedef struct {
      logic [1:0]  vsel;
      logic [63:0] data;
      logic [3:0]  count;
      logic        eom;
      logic        known_ok;
      logic [63:0] known_first;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_data_word;
   logic [3:0]  req_byte_count;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_digest_word;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_final_word;
   logic        csr_write_enable;
   logic [1:0]  csr_write_data;

   // hash model state
   logic [63:0]  chain [8];
   logic [7:0]   block_bytes [128];
   int           fill;
   logic [127:0] msg_bits;
   logic [1:0]   cur_variant;

   digest_word_type digest_q [$];
   int           fail_count;
   int           cycle_count;
   int           snd_idle_pct;
   int           rcv_idle_pct;
   int           hold_left;
   stim_row_type dir_rows [14];

   sha512_family_hash u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_valid_bytes    (rsp_valid_bytes),
      .rsp_final_word     (rsp_final_word),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // one 80-round compression of the buffered block
   task automatic compress_block();
      logic [63:0] w [80];
      logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) begin
         w[t] = {block_bytes[8*t], block_bytes[8*t+1], block_bytes[8*t+2], block_bytes[8*t+3],
                 block_bytes[8*t+4], block_bytes[8*t+5], block_bytes[8*t+6], block_bytes[8*t+7]};
      end
      for (int t = 16; t < 80; t++) begin
         s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
         s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 80; t++) begin
         t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
              + ROUND_K[t] + w[t];
         t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endtask

   task automatic take_byte(input logic [7:0] v);
      block_bytes[fill] = v;
      fill++;
      if (fill == 128) begin
         compress_block();
         fill = 0;
      end
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) chain[i] = START_IV[{cur_variant, 3'(i)}];
      fill = 0;
      msg_bits = '0;
   endtask

   // absorb one request, and on end of message queue the digest words
   task automatic hash_request(input logic [63:0] data, input logic [3:0] cnt,
                               input logic eom);
      int n;
      int nwords;
      logic [127:0] len;
      digest_word_type dw;
      n = (cnt > 8) ? 8 : int'(cnt);
      for (int i = 0; i < n; i++) take_byte(data[63-8*i -: 8]);
      msg_bits += 128'(n * 8);
      if (eom) begin
         len = msg_bits;
         take_byte(8'h80);
         while (fill != 112) take_byte(8'h00);
         for (int i = 0; i < 16; i++) take_byte(len[127-8*i -: 8]);
         case (cur_variant)
            sha512_pkg::VAR_512: nwords = 8;
            sha512_pkg::VAR_384: nwords = 6;
            default: nwords = 4;
         endcase
         for (int k = 0; k < nwords; k++) begin
            dw.word = chain[k];
            dw.nbytes = 4'd8;
            dw.last = (k == nwords - 1);
            if (cur_variant == sha512_pkg::VAR_512_224 && dw.last) begin
               dw.word[31:0] = '0;
               dw.nbytes = 4'd4;
            end
            digest_q.push_back(dw);
         end
         restart_hash();
      end
   endtask

   // wait out all digests, let the block settle, then write the variant
   task automatic write_variant(input logic [1:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_variant = v;
      restart_hash();
   endtask

   task automatic send_request(input logic [63:0] data, input logic [3:0] cnt,
                               input logic eom);
      req_valid <= 1'b1;
      req_data_word <= data;
      req_byte_count <= cnt;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      hash_request(data, cnt, eom);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // random message of nwords words, mostly full
   task automatic send_random_message(input int nwords);
      logic [3:0] cnt;
      for (int i = 0; i < nwords; i++) begin
         cnt = ($urandom_range(99) < 70) ? 4'd8 : 4'($urandom_range(15));
         send_request({$urandom, $urandom}, cnt, i == nwords - 1);
      end
   endtask

   // response side: check and drive ready
   always @(posedge clock) begin
      digest_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            $error("unexpected digest word %h", rsp_digest_word);
            fail_count++;
         end else begin
            exp_w = digest_q.pop_front();
            if (rsp_digest_word !== exp_w.word) begin
               $error("digest_word expected %h actual %h", exp_w.word, rsp_digest_word);
               fail_count++;
            end
            if (rsp_valid_bytes !== exp_w.nbytes) begin
               $error("valid_bytes expected %0d actual %0d", exp_w.nbytes, rsp_valid_bytes);
               fail_count++;
            end
            if (rsp_final_word !== exp_w.last) begin
               $error("final_word expected %0d actual %0d", exp_w.last, rsp_final_word);
               fail_count++;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_byte_count = '0;
      req_end_of_message = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      fail_count = 0;
      cycle_count = 0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_left = 0;
      cur_variant = sha512_pkg::VAR_512;
      restart_hash();

      // directed: empty and short messages per variant, byte count extremes,
      // abort of a message in progress by a variant write
      dir_rows[0]  = '{sha512_pkg::VAR_512, 64'h0, 4'd0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd};
      dir_rows[1]  = '{sha512_pkg::VAR_512, 64'h6162630000000000, 4'd3, 1'b1, 1'b1,
                       64'hddaf35a193617aba};
      dir_rows[2]  = '{sha512_pkg::VAR_512, 64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 64'h0};
      dir_rows[3]  = '{sha512_pkg::VAR_384, 64'h0, 4'd0, 1'b1, 1'b1, 64'h38b060a751ac9638};
      dir_rows[4]  = '{sha512_pkg::VAR_512_224, 64'h0, 4'd0, 1'b1, 1'b1,
                       64'h6ed0dd02806fa89e};
      dir_rows[5]  = '{sha512_pkg::VAR_512_256, 64'h0, 4'd0, 1'b1, 1'b1,
                       64'hc672b8d1ef56ed28};
      dir_rows[6]  = '{sha512_pkg::VAR_512_256, 64'hffffffffffffffff, 4'd15, 1'b0, 1'b0,
                       64'h0};
      dir_rows[7]  = '{sha512_pkg::VAR_512_256, 64'h0, 4'd9, 1'b0, 1'b0, 64'h0};
      dir_rows[8]  = '{sha512_pkg::VAR_512_256, 64'hffffffffffffffff, 4'd0, 1'b0, 1'b0,
                       64'h0};
      dir_rows[9]  = '{sha512_pkg::VAR_512_256, 64'h0123456789abcdef, 4'd7, 1'b0, 1'b0,
                       64'h0};
      dir_rows[10] = '{sha512_pkg::VAR_512_256, 64'hfedcba9876543210, 4'd8, 1'b1, 1'b0,
                       64'h0};
      dir_rows[11] = '{sha512_pkg::VAR_512_224, 64'haaaaaaaaaaaaaaaa, 4'd5, 1'b1, 1'b0,
                       64'h0};
      dir_rows[12] = '{sha512_pkg::VAR_384, 64'h5555555555555555, 4'd1, 1'b0, 1'b0, 64'h0};
      dir_rows[13] = '{sha512_pkg::VAR_384, 64'hffffffffffffffff, 4'd8, 1'b1, 1'b0, 64'h0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a known row starts a fresh message, so its digest heads the queue
      foreach (dir_rows[r]) begin
         if (dir_rows[r].vsel != cur_variant) write_variant(dir_rows[r].vsel);
         send_request(dir_rows[r].data, dir_rows[r].count, dir_rows[r].eom);
         if (dir_rows[r].known_ok && digest_q[0].word !== dir_rows[r].known_first) begin
            $error("digest_word expected %h predicted %h", dir_rows[r].known_first,
                   digest_q[0].word);
            fail_count++;
         end
      end
      // same variant rewritten mid-message
      send_request({$urandom, $urandom}, 4'd8, 1'b0);
      write_variant(cur_variant);

      // random messages through the idling phases
      for (int ph = 0; ph < 4; ph++) begin
         snd_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 57 : 20) : 0;
         rcv_idle_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 57 : 20) : 0;
         if (ph == 0) hold_left = 600;
         for (int m = 0; m < 6; m++) begin
            if ($urandom_range(2) == 0) write_variant(2'($urandom_range(3)));
            if (m == 5 && ph == 3) send_random_message($urandom_range(16, 20));
            else send_random_message($urandom_range(1, 10));
         end
      end

      // drain
      req_valid <= 1'b0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sha512_family_hash.f */
hdl/sha512_pkg.sv
hdl/sha512_family_hash.sv
test/sha512_family_hash_test.sv
